FILE: sv/deferred_and_periodic_timer_table_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the timer table
// Implication checks on the rising clock edge, disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef DEFERRED_AND_PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH
`define DEFERRED_AND_PERIODIC_TIMER_TABLE_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication
`define DPT_ASSERT_IMPL(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
    else $error("assertion failed: a implies b");

// Next-cycle implication
`define DPT_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
    else $error("assertion failed: a implies b next cycle");

`else

`define DPT_ASSERT_IMPL(label, clk, rst_n, a, b)
`define DPT_ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

FILE: sv/dpt_pkg.sv
// ----------------------------------------------------------------------------
// Timer table package
// Slot count, field codes, payload structs and controller/datapath links.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt_pkg;

  // Slot count and index width
  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Command codes
  localparam logic [2:0] CMD_TICK      = 3'd0;
  localparam logic [2:0] CMD_ADD_NEXT  = 3'd1;
  localparam logic [2:0] CMD_ADD_DELAY = 3'd2;
  localparam logic [2:0] CMD_ADD_PER   = 3'd3;
  localparam logic [2:0] CMD_ADD_EVERY = 3'd4;
  localparam logic [2:0] CMD_REMOVE    = 3'd5;

  // Result event codes
  localparam logic [2:0] EV_FIRED    = 3'd0;
  localparam logic [2:0] EV_DONE     = 3'd1;
  localparam logic [2:0] EV_ADDED    = 3'd2;
  localparam logic [2:0] EV_FULL     = 3'd3;
  localparam logic [2:0] EV_REMOVED  = 3'd4;
  localparam logic [2:0] EV_NOTFOUND = 3'd5;

  // Timer kinds
  localparam logic [1:0] KIND_NEXT     = 2'd0;
  localparam logic [1:0] KIND_DELAYED  = 2'd1;
  localparam logic [1:0] KIND_PERIODIC = 2'd2;
  localparam logic [1:0] KIND_EVERY    = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [19:0] elapsed_us;
    logic [31:0] limit_us;
    logic [15:0] callback_tag;
    logic [3:0]  target_slot;
  } dpt_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [3:0]  slot_index;
    logic [15:0] tag_out;
    logic [1:0]  timer_kind;
    logic        last_of_run;
  } dpt_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic emit_fire;
    logic next_kind;
    logic push_done;
    logic single;
  } dpt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic fire_found;
    logic kind_last;
    logic out_free;
  } dpt_sts_t;

endpackage

`default_nettype wire

FILE: sv/dpt_ctrl.sv
// ----------------------------------------------------------------------------
// Timer table controller
// Sequences scan, fire emission and single add/remove operations.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_ctrl import dpt_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [2:0] in_command_i,
  output logic            in_ready_o,
  input  wire dpt_sts_t   sts_i,
  output dpt_cmd_t        cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_SINGLE
  } state_e;

  state_e state_q, state_d;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (in_command_i == CMD_TICK) begin
            state_d = ST_SCAN;
          end else if (in_command_i <= CMD_REMOVE) begin
            state_d = ST_SINGLE;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        priority if (sts_i.fire_found) begin
          cmd_o.emit_fire = sts_i.out_free;
        end else if (!sts_i.kind_last) begin
          cmd_o.next_kind = 1'b1;
        end else begin
          // Issue the done item once the result register is free
          if (sts_i.out_free) begin
            cmd_o.push_done = 1'b1;
            state_d         = ST_IDLE;
          end
        end
      end
      ST_SINGLE: begin
        if (sts_i.out_free) begin
          cmd_o.single = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/dpt_dp.sv
// ----------------------------------------------------------------------------
// Timer table datapath
// Slot storage, one-slot-per-cycle counter update, fire search, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt_dp import dpt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire dpt_in_t in_data_i,
  input  wire logic    out_ready_i,
  output logic         out_valid_o,
  output dpt_out_t     out_data_o,
  input  wire dpt_cmd_t cmd_i,
  output dpt_sts_t     sts_o
);

  logic [SLOTS-1:0] valid_q;
  logic [SLOTS-1:0] pend_q;
  logic [1:0]       kind_q [SLOTS];
  logic [31:0]      cnt_q  [SLOTS];
  logic [31:0]      lim_q  [SLOTS];
  logic [15:0]      tag_q  [SLOTS];

  dpt_in_t          req_q;
  logic [IDX_W-1:0] idx_q;
  logic [1:0]       kind_sel_q;
  logic             out_valid_q;
  dpt_out_t         out_q;

  // Scan: saturating add and fire test for the current slot
  logic [1:0]  cur_kind;
  logic [32:0] sum;
  logic [31:0] sat;
  logic        kind_fire;
  logic        scan_fire;
  logic        timed;

  assign cur_kind = kind_q[idx_q];
  assign sum      = {1'b0, cnt_q[idx_q]} + 33'(req_q.elapsed_us);
  assign sat      = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign timed    = (cur_kind == KIND_DELAYED) || (cur_kind == KIND_PERIODIC);

  always_comb begin
    unique case (cur_kind)
      KIND_NEXT:     kind_fire = 1'b1;
      KIND_DELAYED:  kind_fire = (sat > lim_q[idx_q]);
      KIND_PERIODIC: kind_fire = (sat >= lim_q[idx_q]);
      default:       kind_fire = 1'b1;
    endcase
  end

  assign scan_fire = valid_q[idx_q] && kind_fire;

  // Find lowest pending slot of the selected kind
  logic             fire_found;
  logic [IDX_W-1:0] fire_idx;

  always_comb begin
    fire_found = 1'b0;
    fire_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (pend_q[i] && (kind_q[i] == kind_sel_q)) begin
        fire_found = 1'b1;
        fire_idx   = IDX_W'(i);
      end
    end
  end

  // Find lowest free slot for an add
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Decode the single request
  logic             is_add;
  logic [1:0]       add_kind;
  logic [IDX_W-1:0] tgt_idx;
  logic             tgt_ok;

  assign is_add   = (req_q.command != CMD_REMOVE);
  assign add_kind = 2'(req_q.command - CMD_ADD_NEXT);
  assign tgt_idx  = IDX_W'(req_q.target_slot);
  assign tgt_ok   = (32'(req_q.target_slot) < 32'(SLOTS)) && valid_q[tgt_idx] &&
                    ((kind_q[tgt_idx] == KIND_PERIODIC) || (kind_q[tgt_idx] == KIND_EVERY));

  // Build the next result item
  dpt_out_t res;

  always_comb begin
    res = '0;
    priority if (cmd_i.emit_fire) begin
      res.event_res  = EV_FIRED;
      res.slot_index = 4'(fire_idx);
      res.tag_out    = tag_q[fire_idx];
      res.timer_kind = kind_sel_q;
    end else if (cmd_i.push_done) begin
      res.event_res   = EV_DONE;
      res.last_of_run = 1'b1;
    end else if (is_add) begin
      res.event_res   = free_found ? EV_ADDED : EV_FULL;
      res.slot_index  = free_found ? 4'(free_idx) : 4'd0;
      res.tag_out     = req_q.callback_tag;
      res.timer_kind  = add_kind;
      res.last_of_run = 1'b1;
    end else begin
      res.event_res   = tgt_ok ? EV_REMOVED : EV_NOTFOUND;
      res.slot_index  = req_q.target_slot;
      res.tag_out     = tgt_ok ? tag_q[tgt_idx] : 16'd0;
      res.timer_kind  = tgt_ok ? kind_q[tgt_idx] : KIND_NEXT;
      res.last_of_run = 1'b1;
    end
  end

  logic push;
  assign push = cmd_i.emit_fire || cmd_i.push_done || cmd_i.single;

  // Control state: valid bits, pending bits, walk indexes, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      pend_q      <= '0;
      idx_q       <= '0;
      kind_sel_q  <= KIND_NEXT;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        idx_q      <= '0;
        kind_sel_q <= KIND_NEXT;
      end
      if (cmd_i.scan_step) begin
        pend_q[idx_q] <= scan_fire;
        if (scan_fire && ((cur_kind == KIND_NEXT) || (cur_kind == KIND_DELAYED))) begin
          valid_q[idx_q] <= 1'b0;
        end
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.emit_fire) begin
        pend_q[fire_idx] <= 1'b0;
      end
      if (cmd_i.next_kind) begin
        kind_sel_q <= kind_sel_q + 2'd1;
      end
      if (cmd_i.single) begin
        if (is_add && free_found) begin
          valid_q[free_idx] <= 1'b1;
        end else if (!is_add && tgt_ok) begin
          valid_q[tgt_idx] <= 1'b0;
        end
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: request, slot fields, result
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= in_data_i;
    end
    if (cmd_i.scan_step && valid_q[idx_q] && timed) begin
      cnt_q[idx_q] <= kind_fire ? 32'd0 : sat;
    end
    if (cmd_i.single && is_add && free_found) begin
      kind_q[free_idx] <= add_kind;
      cnt_q[free_idx]  <= 32'd0;
      lim_q[free_idx]  <= req_q.limit_us;
      tag_q[free_idx]  <= req_q.callback_tag;
    end
    if (push) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign sts_o.scan_last  = (idx_q == IDX_W'(SLOTS - 1));
  assign sts_o.fire_found = fire_found;
  assign sts_o.kind_last  = (kind_sel_q == KIND_EVERY);
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

FILE: sv/deferred_and_periodic_timer_table_top.sv
// ----------------------------------------------------------------------------
// Deferred and periodic timer table
// Slot table of next-tick, delayed, periodic and every-tick timers.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o   in_data_i   (dpt_in_t)
//   out      output     out_valid_o/out_ready_i out_data_o  (dpt_out_t)
//
// A tick is accepted, scans all SLOTS slots (one counter add and compare
// per slot), then emits one fire event per pending slot for each of the
// four kinds in turn, the last issuing the done item. Add and remove wait
// for a free result register. Reset clears all slot valid bits at once.
// A stalled output register holds emission until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module deferred_and_periodic_timer_table_top import dpt_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire dpt_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output dpt_out_t     out_data_o
);

  dpt_cmd_t cmd;
  dpt_sts_t sts;

  dpt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_data_i.command),
    .in_ready_o   (in_ready_o),
    .sts_i        (sts),
    .cmd_o        (cmd)
  );

  dpt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

`include "deferred_and_periodic_timer_table_top_assert.svh"

  // An accepted tick, add or remove leaves the idle state
  `DPT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_valid_i && in_ready_o && (in_data_i.command <= CMD_REMOVE), !in_ready_o)

  // No result is produced while idle
  `DPT_ASSERT_IMPL(a_no_push_idle, clk_i, rst_ni, in_ready_o, !(cmd.emit_fire || cmd.push_done || cmd.single))

  // Never overwrite a result that is still waiting
  `DPT_ASSERT_IMPL(a_no_overwrite, clk_i, rst_ni, out_valid_o && !out_ready_i, !(cmd.emit_fire || cmd.push_done || cmd.single))

endmodule

`default_nettype wire
